// ----- rtl/lcsl_pkg.sv -----
// shared types and constants for the lru cache set lookup block
// no dependencies

package lcsl_pkg;

    localparam int MAX_WAYS   = 8;
    localparam int TAG_BITS   = 20;
    localparam int CFG_W      = 4;
    localparam int RANK_W     = 3;
    localparam int CNT_W      = $clog2(MAX_WAYS + 1);
    localparam int IDX_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RES_BITS   = 1 + RANK_W + 1 + TAG_BITS;
    localparam int S_TDATA_W  = ((TAG_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((RES_BITS + 7) / 8) * 8;

    typedef logic [TAG_BITS-1:0] t_tag;

    typedef struct packed {
        logic              hit;
        logic [RANK_W-1:0] hit_rank;
        logic              evicted;
        t_tag              evicted_tag;
    } t_result;

endpackage

// ----- rtl/lcsl_tag_set.sv -----
// tag store ordered by recency, line count, associativity register
// and the lookup / update logic; depends on lcsl_pkg

module lcsl_tag_set
    import lcsl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_update,
    input  t_tag             i_tag,
    output t_result          o_result
);

    t_tag             r_tags [MAX_WAYS];
    t_tag             n_tags [MAX_WAYS];
    logic [CFG_W-1:0] r_ways;
    logic [CNT_W-1:0] r_held;
    logic [CNT_W-1:0] n_held;

    logic [CNT_W-1:0] eff_ways;
    logic [CNT_W-1:0] held;
    logic [CNT_W-1:0] upto;
    logic [MAX_WAYS-1:0] match;
    logic             hit;
    logic [IDX_W-1:0] rank;
    logic             evict;
    logic [IDX_W-1:0] tail_idx;

    // clamp associativity to 1..MAX_WAYS
    always_comb begin
        if (r_ways == '0) begin
            eff_ways = CNT_W'(1);
        end else if (32'(r_ways) > MAX_WAYS) begin
            eff_ways = CNT_W'(MAX_WAYS);
        end else begin
            eff_ways = CNT_W'(r_ways);
        end
        held = (r_held > eff_ways) ? eff_ways : r_held;
    end

    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            match[i] = (CNT_W'(i) < held) && (r_tags[i] == i_tag);
        end
    end

    // first match wins
    always_comb begin
        hit  = 1'b0;
        rank = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit  = 1'b1;
                rank = IDX_W'(i);
            end
        end
    end

    always_comb begin
        tail_idx = IDX_W'(held - CNT_W'(1));
        evict    = !hit && (held >= eff_ways);
        n_held   = r_held;
        if (hit) begin
            upto = CNT_W'(rank);
        end else if (!evict) begin
            upto   = held;
            n_held = held + CNT_W'(1);
        end else begin
            upto   = held - CNT_W'(1);
            n_held = held;
        end
    end

    always_comb begin
        n_tags[0] = i_tag;
        for (int i = 1; i < MAX_WAYS; i++) begin
            n_tags[i] = (CNT_W'(i) <= upto) ? r_tags[i-1] : r_tags[i];
        end
    end

    always_comb begin
        o_result.hit         = hit;
        o_result.hit_rank    = RANK_W'(rank);
        o_result.evicted     = evict;
        o_result.evicted_tag = evict ? r_tags[tail_idx] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ways <= CFG_W'(1);
            r_held <= '0;
        end else if (i_cfg_wr) begin
            r_ways <= i_cfg_data;
            r_held <= '0;
        end else if (i_update) begin
            r_held <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_update && !i_cfg_wr) begin
            for (int i = 0; i < MAX_WAYS; i++) begin
                r_tags[i] <= n_tags[i];
            end
        end
    end

endmodule

// ----- rtl/lru_cache_set_lookup_core.sv -----
// top level of the lru cache set lookup block: stream ports, input and
// result registers; depends on lcsl_pkg and lcsl_tag_set
//
// usage:
//   s_axis carries one access word per beat, the tag in the low bits.
//   m_axis returns one result word per access, in access order.
//   the cfg channel writes the associativity; any write empties the set.
//   write it only while no access is in flight.
// datapath: the access word is held in the input register, and its result
//   word is loaded into the result register when the input register advances.
// throughput: one access per cycle while m_axis is not stalled; the tag
//   compare, recency shift and eviction pick are all combinational between
//   the input register and the result register, so each access sees the
//   state left by the one before it.
// reset: set empty, associativity 1, both registers empty.
// stall: when m_axis_tready is low the result register holds, the input
//   register fills, and then s_axis_tready drops; nothing is lost.

module lru_cache_set_lookup_core
    import lcsl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_W-1:0]     i_cfg_data,    // ways_in_use
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // access_tag
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata   // hit, hit_rank, evicted, evicted_tag
);

    logic    r_in_valid;
    t_tag    r_in_tag;
    logic    r_out_valid;
    t_result r_out;
    t_result result;
    logic    advance;
    logic    cfg_wr;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;
    assign cfg_wr        = i_cfg_valid;

    lcsl_tag_set u_tag_set (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (cfg_wr),
        .i_cfg_data (i_cfg_data),
        .i_update   (advance),
        .i_tag      (r_in_tag),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_tag <= s_axis_tdata[TAG_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'({r_out.evicted_tag, r_out.evicted,
                                       r_out.hit_rank, r_out.hit});

endmodule

// ----- tb/sv/tb_lru_cache_set_lookup_core.sv -----
`timescale 1ns / 1ps
// testbench for lru_cache_set_lookup_core: directed and random tag accesses
// checked word by word against a behavioral lru set model kept in this file
// depends on lcsl_pkg and the lru_cache_set_lookup_core rtl

module tb_lru_cache_set_lookup_core;
    import lcsl_pkg::*;

    localparam int   IDLE_LIMIT = 4000;
    localparam int   DRAIN_GAP  = 6;
    localparam t_tag TAG_ONES   = '1;
    localparam t_tag TAG_ZERO   = '0;

    typedef struct {
        bit              hit;
        bit [RANK_W-1:0] hit_rank;
        bit              evicted;
        t_tag            evicted_tag;
    } t_lookup_res;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_W-1:0]     i_cfg_data;     // ways_in_use
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;   // access_tag
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;   // hit, hit_rank, evicted, evicted_tag

    // lru set model state
    logic [CFG_W-1:0] model_ways;
    int unsigned      model_held;
    t_tag             model_tags [MAX_WAYS];

    t_lookup_res pending_lookups [$];
    int          error_count;
    int          access_count;
    int          hit_count;
    int          evict_count;
    int          ways_writes;
    int          idle_cycles;
    bit          no_idle;

    lru_cache_set_lookup_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    function automatic bit take_break();
        return !no_idle && ($urandom_range(0, 99) < 7);
    endfunction

    function automatic t_lookup_res predict_lookup(input t_tag tag);
        t_lookup_res r;
        int unsigned ways;
        int unsigned held;
        int unsigned pos;
        int unsigned upto;
        int unsigned i;
        r = '{default: 0};
        ways = (model_ways == 0) ? 1 : ((model_ways > MAX_WAYS) ? MAX_WAYS : model_ways);
        held = (model_held > ways) ? ways : model_held;
        pos = held;
        for (i = 0; i < held; i++) begin
            if (pos == held && model_tags[i] == tag) begin
                pos = i;
            end
        end
        if (pos < held) begin
            r.hit = 1'b1;
            r.hit_rank = pos[RANK_W-1:0];
            upto = pos;
        end else if (held < ways) begin
            upto = held;
            held++;
        end else begin
            r.evicted = 1'b1;
            r.evicted_tag = model_tags[held-1];
            upto = held - 1;
        end
        for (i = upto; i > 0; i--) begin
            model_tags[i] = model_tags[i-1];
        end
        model_tags[0] = tag;
        model_held = held;
        return r;
    endfunction

    task automatic send_access(input t_tag tag);
        t_lookup_res r;
        if (take_break()) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W-TAG_BITS){1'b0}}, tag};
        do @(posedge i_clk); while (!s_axis_tready);
        r = predict_lookup(tag);
        pending_lookups.push_back(r);
        access_count++;
        hit_count   += r.hit;
        evict_count += r.evicted;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic write_ways(input logic [CFG_W-1:0] ways);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= ways;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        model_ways = ways;
        model_held = 0;
        ways_writes++;
    endtask

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        t_lookup_res exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_lookups.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, m_axis_tdata);
                error_count++;
            end else begin
                exp_r = pending_lookups.pop_front();
                if (m_axis_tdata[0] !== exp_r.hit) begin
                    $display("%0t: hit expected %0d actual %0d",
                             $time, exp_r.hit, m_axis_tdata[0]);
                    error_count++;
                end
                if (m_axis_tdata[3:1] !== exp_r.hit_rank) begin
                    $display("%0t: hit_rank expected %0d actual %0d",
                             $time, exp_r.hit_rank, m_axis_tdata[3:1]);
                    error_count++;
                end
                if (m_axis_tdata[4] !== exp_r.evicted) begin
                    $display("%0t: evicted expected %0d actual %0d",
                             $time, exp_r.evicted, m_axis_tdata[4]);
                    error_count++;
                end
                if (m_axis_tdata[24:5] !== exp_r.evicted_tag) begin
                    $display("%0t: evicted_tag expected %h actual %h",
                             $time, exp_r.evicted_tag, m_axis_tdata[24:5]);
                    error_count++;
                end
            end
        end
        m_axis_tready <= !take_break();
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
                $display("tb_lru_cache_set_lookup_core: FAIL");
                $finish;
            end
        end
    end

    task automatic test_reset_single_way();
        send_access(TAG_ZERO);
        send_access(TAG_ZERO);
        send_access(TAG_ONES);
    endtask

    task automatic test_small_set();
        write_ways(4'd3);
        send_access(20'h0000A);
        send_access(20'h0000B);
        send_access(20'h0000C);
        send_access(20'h0000A);
        send_access(20'h0000D);
    endtask

    task automatic test_full_eight_ways();
        int i;
        write_ways(4'd15);
        for (i = 0; i < MAX_WAYS; i++) begin
            send_access(t_tag'(20'h55555 ^ (i << 17)));
        end
        send_access(20'h55555);
        send_access(TAG_ONES);
        write_ways(4'd0);
        send_access(TAG_ONES);
        send_access(TAG_ZERO);
    endtask

    task automatic run_random_phase(input logic [CFG_W-1:0] ways, input int n_items);
        t_tag        pool [$];
        int unsigned eff;
        int          i;
        int unsigned pick;
        write_ways(ways);
        eff = (ways == 0) ? 1 : ((ways > MAX_WAYS) ? MAX_WAYS : ways);
        repeat (eff + $urandom_range(1, 4)) pool.push_back(t_tag'($urandom));
        for (i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                send_access(pool[$urandom_range(0, pool.size() - 1)]);
            end else if (pick < 95) begin
                send_access(t_tag'($urandom));
            end else begin
                send_access($urandom_range(0, 1) ? TAG_ONES : TAG_ZERO);
            end
        end
    endtask

    task automatic test_random_settings();
        logic [CFG_W-1:0] plan [12] = '{4'd2, 4'd8, 4'd1, 4'd5, 4'd15, 4'd0,
                                         4'd3, 4'd7, 4'd4, 4'd9, 4'd6, 4'd8};
        int p;
        for (p = 0; p < 12; p++) begin
            no_idle = (p == 4);
            run_random_phase(plan[p], 125);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_drain_pause();
        run_random_phase(4'd6, 30);
        wait_drained();
        run_random_phase(4'd6, 30);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        model_ways    = 4'd1;
        model_held    = 0;
        for (int k = 0; k < MAX_WAYS; k++) model_tags[k] = '0;
        error_count   = 0;
        access_count  = 0;
        hit_count     = 0;
        evict_count   = 0;
        ways_writes   = 0;
        idle_cycles   = 0;
        no_idle       = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_single_way();
        test_small_set();
        test_full_eight_ways();
        test_random_settings();
        test_drain_pause();
        wait_drained();

        $display("covered %0d accesses (%0d hits, %0d evictions) over %0d way settings",
                 access_count, hit_count, evict_count, ways_writes + 1);
        $display("way settings included 0, 1, 8 and out of range values 9 and 15");
        if (error_count == 0) begin
            $display("tb_lru_cache_set_lookup_core: PASS");
        end else begin
            $display("tb_lru_cache_set_lookup_core: FAIL");
        end
        $finish;
    end

endmodule
